/* src/pftg_pkg.sv */
// Shared types, constants and hash functions for the packet filter tag generator.
`timescale 1ns / 1ps

package pftg_pkg;

	localparam int unsigned HASH_BYTES = 18;

	localparam logic [63:0] FNV_OFFSET = 64'hCBF2_9CE4_8422_2325;

	// short tag fold constants
	localparam logic [7:0] S0_XOR = 8'd193;
	localparam logic [7:0] S1_XOR = 8'd113;

	// long tag byte offsets and select values
	localparam logic [7:0] T0_OFS  = 8'd42;
	localparam logic [7:0] T1_OFS  = 8'd200;
	localparam logic [7:0] T2_OFS  = 8'd5;
	localparam logic [7:0] T4_OFS  = 8'd78;
	localparam logic [7:0] T5_OFS  = 8'd96;
	localparam logic [7:0] T6_OFS  = 8'd100;
	localparam logic [7:0] T7_ONE  = 8'd7;
	localparam logic [7:0] T7_ZERO = 8'd79;
	localparam logic [7:0] T8_ONE  = 8'd83;
	localparam logic [7:0] T8_ZERO = 8'd37;
	localparam logic [7:0] T9_OFS  = 8'd124;
	localparam logic [7:0] T10_OFS = 8'd175;
	localparam logic [7:0] T11_OFS = 8'd33;
	localparam logic [7:0] T12_SEL0 = 8'd97;
	localparam logic [7:0] T12_SEL1 = 8'd5;
	localparam logic [7:0] T12_SEL2 = 8'd43;
	localparam logic [7:0] T12_SEL3 = 8'd13;
	localparam logic [7:0] T13_OFS = 8'd210;
	localparam logic [7:0] T14_OFS = 8'd17;

	typedef logic [1:0] sel_t;
	localparam sel_t SEL_0 = 2'd0;
	localparam sel_t SEL_1 = 2'd1;
	localparam sel_t SEL_2 = 2'd2;
	localparam sel_t SEL_3 = 2'd3;

	typedef struct packed {
		logic [63:0] hash;
		logic [31:0] src;
		logic [31:0] dst;
		logic [15:0] len;
		logic [15:0] stag;
	} stage_t;

	// one FNV-1a round; the prime 2^40 + 0x1B3 is a sum of shifted copies
	function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
		logic [63:0] x;
		begin
			x = h ^ {56'd0, b};
			fnv_step = x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8)
				+ (x << 40);
		end
	endfunction

	function automatic logic [15:0] short_tag_f(input logic [31:0] src,
			input logic [31:0] dst, input logic [15:0] len);
		logic [11:0] sum;
		logic [7:0]  s0;
		logic [7:0]  s1;
		begin
			sum = 12'(src[7:0]) + 12'(src[15:8]) + 12'(src[23:16]) + 12'(src[31:24])
				+ 12'(dst[7:0]) + 12'(dst[15:8]) + 12'(dst[23:16]) + 12'(dst[31:24])
				+ 12'(len[7:0]) + 12'(len[15:8]);
			s0 = 8'd1 | (sum[7:0] ^ {4'd0, sum[11:8]} ^ S0_XOR);
			s1 = 8'd1 | (~s0 ^ S1_XOR);
			short_tag_f = {s1, s0};
		end
	endfunction

endpackage

/* src/pftg_fnv_step.sv */
// One pipeline stage: hashes one byte into the running FNV-1a value.
`timescale 1ns / 1ps

module pftg_fnv_step (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	output logic              up_ready,
	input  pftg_pkg::stage_t  up_data,
	input  logic [7:0]        up_byte,
	output logic              dn_valid,
	input  logic              dn_ready,
	output pftg_pkg::stage_t  dn_data
);

	logic             valid_q;
	pftg_pkg::stage_t data_q;

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= {pftg_pkg::fnv_step(up_data.hash, up_byte), up_data.src, up_data.dst,
				up_data.len, up_data.stag};
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;

endmodule

/* src/pftg_tag_out.sv */
// Output stage: maps the final hash onto the long tag bytes and holds the result.
`timescale 1ns / 1ps

module pftg_tag_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	output logic              up_ready,
	input  pftg_pkg::stage_t  up_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [15:0]       short_tag,
	output logic [63:0]       long_tag_low,
	output logic [55:0]       long_tag_high
);

	logic        valid_q;
	logic [15:0] stag_q;
	logic [63:0] low_q;
	logic [55:0] high_q;
	logic [63:0] h;
	logic [7:0]  t [15];

	assign h = up_data.hash;

	always_comb begin
		t[0]  = 8'(h[55:54]) + pftg_pkg::T0_OFS;
		t[1]  = 8'(h[28:24]) + pftg_pkg::T1_OFS;
		t[2]  = 8'(h[23:18]) + pftg_pkg::T2_OFS;
		t[3]  = h[7:0];
		t[4]  = 8'(h[17:16]) + pftg_pkg::T4_OFS;
		t[5]  = 8'(h[38:32]) + pftg_pkg::T5_OFS;
		t[6]  = 8'(h[15:10]) + pftg_pkg::T6_OFS;
		t[7]  = h[56] ? pftg_pkg::T7_ONE : pftg_pkg::T7_ZERO;
		t[8]  = h[39] ? pftg_pkg::T8_ONE : pftg_pkg::T8_ZERO;
		t[9]  = 8'(h[42:40]) + pftg_pkg::T9_OFS;
		t[10] = 8'(h[15:13]) + pftg_pkg::T10_OFS;
		t[11] = 8'(h[53:48]) + pftg_pkg::T11_OFS;
		unique case (h[9:8])
			pftg_pkg::SEL_0: t[12] = pftg_pkg::T12_SEL0;
			pftg_pkg::SEL_1: t[12] = pftg_pkg::T12_SEL1;
			pftg_pkg::SEL_2: t[12] = pftg_pkg::T12_SEL2;
			default:         t[12] = pftg_pkg::T12_SEL3;
		endcase
		t[13] = 8'(h[47:43]) + pftg_pkg::T13_OFS;
		t[14] = 8'(h[63:57]) + pftg_pkg::T14_OFS;
	end

	assign up_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			stag_q <= up_data.stag;
			low_q  <= {t[7], t[6], t[5], t[4], t[3], t[2], t[1], t[0]};
			high_q <= {t[14], t[13], t[12], t[11], t[10], t[9], t[8]};
		end
	end

	assign out_valid     = valid_q;
	assign short_tag     = stag_q;
	assign long_tag_low  = low_q;
	assign long_tag_high = high_q;

endmodule

/* src/packet_filter_tag_generator_top.sv */
// Top level of the packet filter tag generator: input fold, hash pipeline, tag output.
//
//   port group   direction  handshake             payload
//   in           input      in_valid / in_ready   src_addr, dst_addr, pkt_len
//   out          output     out_valid / out_ready short_tag, long_tag_low, long_tag_high
//   cfg          input      cfg_valid / cfg_ready magic_word
//
// One item per cycle sustained while out_ready is high.
// The 18 hash stages each run one FNV-1a round (xor plus shifted-add constant multiply),
// and one more stage maps the hash onto the tag bytes.
// Each stage has its own valid bit and advances when the stage after it is empty or moving,
// so bubbles close up under an output stall and nothing is dropped or repeated.
// Reset clears all valid bits and the magic register to zero; cfg_ready is always high.
`timescale 1ns / 1ps

module packet_filter_tag_generator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] src_addr,
	input  logic [31:0] dst_addr,
	input  logic [15:0] pkt_len,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] short_tag,
	output logic [63:0] long_tag_low,
	output logic [55:0] long_tag_high,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [63:0] magic_word
);

	localparam int unsigned NSTG = pftg_pkg::HASH_BYTES;

	logic [63:0]      magic_q;
	pftg_pkg::stage_t in_data;
	logic             stg_valid [NSTG];
	logic             stg_ready [NSTG];
	pftg_pkg::stage_t stg_data  [NSTG];
	logic             tag_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= 64'd0;
		end else if (cfg_valid && cfg_ready) begin
			magic_q <= magic_word;
		end
	end

	always_comb begin
		in_data.hash = pftg_pkg::FNV_OFFSET;
		in_data.src  = src_addr;
		in_data.dst  = dst_addr;
		in_data.len  = pkt_len;
		in_data.stag = pftg_pkg::short_tag_f(src_addr, dst_addr, pkt_len);
	end

	for (genvar k = 0; k < NSTG; k++) begin : g_stage
		logic             up_valid;
		pftg_pkg::stage_t up_data;
		logic             dn_ready;
		logic [143:0]     msg;

		if (k == 0) begin : g_first
			assign up_valid = in_valid;
			assign up_data  = in_data;
			assign in_ready = stg_ready[0];
		end else begin : g_mid
			assign up_valid = stg_valid[k-1];
			assign up_data  = stg_data[k-1];
		end

		if (k == NSTG - 1) begin : g_last
			assign dn_ready = tag_ready;
		end else begin : g_next
			assign dn_ready = stg_ready[k+1];
		end

		// hash order: magic bytes, source, destination, length
		assign msg = {up_data.len, up_data.dst, up_data.src, magic_q};

		pftg_fnv_step u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (up_valid),
			.up_ready (stg_ready[k]),
			.up_data  (up_data),
			.up_byte  (msg[8*k +: 8]),
			.dn_valid (stg_valid[k]),
			.dn_ready (dn_ready),
			.dn_data  (stg_data[k])
		);
	end

	pftg_tag_out u_tag (
		.clk           (clk),
		.arst_n        (arst_n),
		.up_valid      (stg_valid[NSTG-1]),
		.up_ready      (tag_ready),
		.up_data       (stg_data[NSTG-1]),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.short_tag     (short_tag),
		.long_tag_low  (long_tag_low),
		.long_tag_high (long_tag_high)
	);

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> stg_valid[0])
		else $error("accepted item did not reach the first stage");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		stg_valid[NSTG-1] && tag_ready |=> out_valid)
		else $error("last hash stage item lost before output");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && stg_valid[NSTG-1] |-> !tag_ready)
		else $error("output stage overwritten while stalled");

endmodule
